// ----- rtl/sbt_pkg.sv -----
// Shared types and character codes for the s-expression byte tokenizer.
// No dependencies; used by sbt_lex_step and sexpr_byte_tokenizer_unit.
`timescale 1ns / 1ps

package sbt_pkg;

  typedef enum logic [2:0] {
    KIND_LPAREN  = 3'd0,
    KIND_RPAREN  = 3'd1,
    KIND_QUOTE   = 3'd2,
    KIND_NUMBER  = 3'd3,
    KIND_SYMCHAR = 3'd4,
    KIND_END     = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_NUMBER = 2'd2,
    PH_SYMBOL = 2'd3
  } phase_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef struct packed {
    phase_t      phase;
    logic [63:0] acc;
    logic        neg;
    logic [7:0]  held;
  } lex_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
    logic [7:0]  ch;
    logic        fin;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } step_out_t;

endpackage

// ----- rtl/sexpr_byte_tokenizer_unit.sv -----
// Top level of the s-expression byte tokenizer: input register, lexer state,
// 3-entry token queue. Depends on sbt_pkg and sbt_lex_step.
// A byte goes through the input register, then the token queue, to the master side.
// Throughput: 1 byte per cycle while the master side takes every token; set by the
//   token queue draining one token per cycle, so a byte that yields two tokens holds back the next byte.
// Reset: rst (synchronous, active high) empties input register and queue and
//   returns the lexer to idle with zeroed accumulator, sign and held char.
`timescale 1ns / 1ps

module sexpr_byte_tokenizer_unit (
  input  logic        clk,
  input  logic        rst,
  // slave side: bytes of the line
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] next_byte
  // master side: tokens
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [63:0] number_value, [71:64] symbol_char,
                                 // [72] symbol_final, [79:73] zero
  output logic [2:0]  m_tuser,   // [2:0] token_kind
  output logic        m_tlast    // run_last: last token caused by this byte
);

  // Input register: one byte waiting for the lexer.
  logic       in_valid;
  logic [7:0] in_byte;

  // Lexer state.
  sbt_pkg::lex_state_t st;
  sbt_pkg::lex_state_t st_next;
  sbt_pkg::step_out_t  step_res;

  // Token queue, q[0] is the head shown on the master side.
  sbt_pkg::token_t q      [0:2];
  sbt_pkg::token_t q_next [0:2];
  logic [1:0]      count;
  logic [1:0]      count_next;
  logic [1:0]      cnt_after;

  logic fire;
  logic pop;

  sbt_lex_step u_step (
    .st      (st),
    .c       (in_byte),
    .st_next (st_next),
    .res     (step_res)
  );

  // The lexer consumes the registered byte only when the queue has room for
  // two tokens, so a byte is never split across cycles.
  assign fire     = in_valid && (count < 2'd2);
  assign pop      = m_tvalid && m_tready;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // all-zero state is idle with cleared accumulator, sign and held char
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // Queue: shift out on pop, then append new tokens behind the survivors.
  always_comb begin
    cnt_after = count - {1'b0, pop};
    if (pop) begin
      q_next[0] = q[1];
      q_next[1] = q[2];
    end else begin
      q_next[0] = q[0];
      q_next[1] = q[1];
    end
    q_next[2] = q[2];
    if (fire && step_res.count != 2'd0) begin
      q_next[cnt_after] = step_res.tok0;
    end
    if (fire && step_res.count == 2'd2) begin
      q_next[cnt_after + 2'd1] = step_res.tok1;
    end
    count_next = cnt_after + (fire ? step_res.count : 2'd0);
  end

  always_ff @(posedge clk) begin
    q[0] <= q_next[0];
    q[1] <= q_next[1];
    q[2] <= q_next[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  assign m_tvalid = (count != 2'd0);
  assign m_tuser  = q[0].kind;
  assign m_tdata  = {7'd0, q[0].fin, q[0].ch, q[0].value};
  assign m_tlast  = q[0].last;

endmodule

// ----- rtl/sbt_lex_step.sv -----
// Combinational lexer step: one byte plus current state gives the next state
// and up to two tokens. Depends on sbt_pkg.
`timescale 1ns / 1ps

module sbt_lex_step (
  input  sbt_pkg::lex_state_t st,
  input  logic [7:0]          c,
  output sbt_pkg::lex_state_t st_next,
  output sbt_pkg::step_out_t  res
);

  typedef struct packed {
    sbt_pkg::lex_state_t st;
    logic                emit;
    sbt_pkg::token_t     tok;
  } start_res_t;

  // Byte seen between tokens.
  function automatic start_res_t start_fn(input logic [7:0] ch,
                                          input sbt_pkg::lex_state_t base);
    start_res_t r;
    r      = '0;
    r.st   = base;
    r.emit = 1'b0;
    r.tok  = '0;
    if (ch == sbt_pkg::CH_NUL) begin
      r.emit     = 1'b1;
      r.tok.kind = sbt_pkg::KIND_END;
      r.st       = '0;
      r.st.phase = sbt_pkg::PH_IDLE;
    end else if (ch == sbt_pkg::CH_SPACE || ch == sbt_pkg::CH_TAB ||
                 ch == sbt_pkg::CH_NL) begin
      r.st.phase = sbt_pkg::PH_IDLE;
    end else if (ch == sbt_pkg::CH_LPAREN) begin
      r.emit     = 1'b1;
      r.tok.kind = sbt_pkg::KIND_LPAREN;
      r.st.phase = sbt_pkg::PH_IDLE;
    end else if (ch == sbt_pkg::CH_RPAREN) begin
      r.emit     = 1'b1;
      r.tok.kind = sbt_pkg::KIND_RPAREN;
      r.st.phase = sbt_pkg::PH_IDLE;
    end else if (ch == sbt_pkg::CH_QUOTE) begin
      r.emit     = 1'b1;
      r.tok.kind = sbt_pkg::KIND_QUOTE;
      r.st.phase = sbt_pkg::PH_IDLE;
    end else if (ch >= sbt_pkg::CH_ZERO && ch <= sbt_pkg::CH_NINE) begin
      r.st.phase = sbt_pkg::PH_NUMBER;
      r.st.acc   = {60'd0, ch[3:0]};
      r.st.neg   = 1'b0;
    end else if (ch == sbt_pkg::CH_PLUS || ch == sbt_pkg::CH_MINUS) begin
      r.st.phase = sbt_pkg::PH_SIGN;
      r.st.held  = ch;
      r.st.neg   = (ch == sbt_pkg::CH_MINUS);
      r.st.acc   = '0;
    end else begin
      r.st.phase = sbt_pkg::PH_SYMBOL;
      r.st.held  = ch;
    end
    return r;
  endfunction

  logic                is_digit;
  logic                is_delim;
  logic [63:0]         acc_x10;
  logic [63:0]         num_val;
  sbt_pkg::lex_state_t base;
  start_res_t          sr;

  assign is_digit = (c >= sbt_pkg::CH_ZERO) && (c <= sbt_pkg::CH_NINE);
  assign is_delim = (c == sbt_pkg::CH_NUL) || (c == sbt_pkg::CH_SPACE) ||
                    (c == sbt_pkg::CH_TAB) || (c == sbt_pkg::CH_NL) ||
                    (c == sbt_pkg::CH_QUOTE) || (c == sbt_pkg::CH_LPAREN) ||
                    (c == sbt_pkg::CH_RPAREN);
  assign acc_x10  = {st.acc[60:0], 3'b000} + {st.acc[62:0], 1'b0} + {60'd0, c[3:0]};
  assign num_val  = st.neg ? (64'd0 - st.acc) : st.acc;

  // State seen by the start-of-token logic once a pending token is flushed.
  always_comb begin
    base       = st;
    base.phase = sbt_pkg::PH_IDLE;
    if (st.phase == sbt_pkg::PH_NUMBER) begin
      base.acc = '0;
      base.neg = 1'b0;
    end else if (st.phase != sbt_pkg::PH_IDLE) begin
      base.held = '0;
    end
  end

  assign sr = start_fn(c, base);

  // Next state.
  always_comb begin
    st_next = st;
    if (st.phase == sbt_pkg::PH_IDLE) begin
      st_next = sr.st;
    end else if (st.phase == sbt_pkg::PH_SIGN && is_digit) begin
      st_next.phase = sbt_pkg::PH_NUMBER;
      st_next.acc   = {60'd0, c[3:0]};
    end else if (st.phase == sbt_pkg::PH_NUMBER && is_digit) begin
      st_next.acc = acc_x10;
    end else if (st.phase == sbt_pkg::PH_NUMBER) begin
      // number ends; the byte is reprocessed as a token start
      st_next = sr.st;
    end else if (is_delim) begin
      // symbol ends on a delimiter (sign or symbol phase)
      st_next = sr.st;
    end else begin
      st_next.phase = sbt_pkg::PH_SYMBOL;
      st_next.held  = c;
    end
  end

  // Tokens.
  always_comb begin
    res = '0;
    if (st.phase == sbt_pkg::PH_IDLE) begin
      if (sr.emit) begin
        res.tok0  = sr.tok;
        res.count = 2'd1;
      end
    end else if (st.phase == sbt_pkg::PH_SIGN && is_digit) begin
      res.count = 2'd0;
    end else if (st.phase == sbt_pkg::PH_NUMBER && is_digit) begin
      res.count = 2'd0;
    end else if (st.phase == sbt_pkg::PH_NUMBER) begin
      res.tok0.kind  = sbt_pkg::KIND_NUMBER;
      res.tok0.value = num_val;
      res.count      = 2'd1;
      if (sr.emit) begin
        res.tok1  = sr.tok;
        res.count = 2'd2;
      end
    end else if (is_delim) begin
      res.tok0.kind = sbt_pkg::KIND_SYMCHAR;
      res.tok0.ch   = st.held;
      res.tok0.fin  = 1'b1;
      res.count     = 2'd1;
      if (sr.emit) begin
        res.tok1  = sr.tok;
        res.count = 2'd2;
      end
    end else begin
      res.tok0.kind = sbt_pkg::KIND_SYMCHAR;
      res.tok0.ch   = st.held;
      res.count     = 2'd1;
    end
    if (res.count == 2'd1) begin
      res.tok0.last = 1'b1;
    end else if (res.count == 2'd2) begin
      res.tok1.last = 1'b1;
    end
  end

endmodule

// ----- tb/sv/sbt_token_check.sv -----
// Token predictor and comparator for the s-expression byte tokenizer bench.
// Depends on sbt_pkg. Watches both stream channels of the unit.
`timescale 1ns / 1ps

module sbt_token_check
  import sbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,
  input  logic [2:0]  m_tuser,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);

  // lexer state mirror
  phase_t      lex_phase;
  logic [63:0] lex_acc;
  logic        lex_neg;
  logic [7:0]  lex_held;

  token_t step_q[$];   // tokens of the byte being lexed
  token_t token_q[$];  // tokens still owed by the unit
  int     mismatches;

  assign fail_count = mismatches;

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL;
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    return c == CH_NUL || is_blank(c) || c == CH_QUOTE || c == CH_LPAREN ||
           c == CH_RPAREN;
  endfunction

  task automatic emit(kind_t k, logic [63:0] v, logic [7:0] c, logic f);
    token_t t;
    t.kind  = k;
    t.value = v;
    t.ch    = c;
    t.fin   = f;
    t.last  = 1'b0;
    step_q.push_back(t);
  endtask

  task automatic clear_lexer();
    lex_phase = PH_IDLE;
    lex_acc   = '0;
    lex_neg   = 1'b0;
    lex_held  = '0;
  endtask

  // byte seen between tokens
  task automatic open_token(logic [7:0] c);
    if (c == CH_NUL) begin
      emit(KIND_END, '0, '0, 1'b0);
      clear_lexer();
    end else if (is_blank(c)) begin
      lex_phase = PH_IDLE;
    end else if (c == CH_LPAREN) begin
      emit(KIND_LPAREN, '0, '0, 1'b0);
      lex_phase = PH_IDLE;
    end else if (c == CH_RPAREN) begin
      emit(KIND_RPAREN, '0, '0, 1'b0);
      lex_phase = PH_IDLE;
    end else if (c == CH_QUOTE) begin
      emit(KIND_QUOTE, '0, '0, 1'b0);
      lex_phase = PH_IDLE;
    end else if (is_digit(c)) begin
      lex_phase = PH_NUMBER;
      lex_acc   = 64'(c - CH_ZERO);
      lex_neg   = 1'b0;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      lex_phase = PH_SIGN;
      lex_held  = c;
      lex_neg   = (c == CH_MINUS);
      lex_acc   = '0;
    end else begin
      lex_phase = PH_SYMBOL;
      lex_held  = c;
    end
  endtask

  // byte seen while a symbol character is held back
  task automatic symbol_byte(logic [7:0] c);
    if (is_delim(c)) begin
      emit(KIND_SYMCHAR, '0, lex_held, 1'b1);
      lex_phase = PH_IDLE;
      lex_held  = '0;
      open_token(c);
    end else begin
      emit(KIND_SYMCHAR, '0, lex_held, 1'b0);
      lex_held = c;
    end
  endtask

  task automatic lex_byte(logic [7:0] c);
    token_t t;
    case (lex_phase)
      PH_IDLE: open_token(c);
      PH_SIGN: begin
        if (is_digit(c)) begin
          lex_phase = PH_NUMBER;
          lex_acc   = 64'(c - CH_ZERO);
        end else begin
          lex_phase = PH_SYMBOL;
          symbol_byte(c);
        end
      end
      PH_NUMBER: begin
        if (is_digit(c)) begin
          lex_acc = lex_acc * 64'd10 + 64'(c - CH_ZERO);
        end else begin
          // terminating byte is not consumed by the number
          emit(KIND_NUMBER, lex_neg ? -lex_acc : lex_acc, '0, 1'b0);
          lex_phase = PH_IDLE;
          lex_acc   = '0;
          lex_neg   = 1'b0;
          open_token(c);
        end
      end
      default: symbol_byte(c);
    endcase
    if (step_q.size() > 0) begin
      t = step_q.pop_back();
      t.last = 1'b1;
      step_q.push_back(t);
    end
    while (step_q.size() > 0) token_q.push_back(step_q.pop_front());
  endtask

  always @(posedge clk) begin
    token_t want;
    if (rst) begin
      clear_lexer();
      step_q.delete();
      token_q.delete();
      mismatches = 0;
      pending <= 0;
    end else begin
      if (s_tvalid && s_tready) lex_byte(s_tdata);
      if (m_tvalid && m_tready) begin
        if (token_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected token kind=%0d value=%0h ch=%0h fin=%b last=%b",
                     $realtime, m_tuser, m_tdata[63:0], m_tdata[71:64], m_tdata[72],
                     m_tlast);
          mismatches++;
        end else begin
          want = token_q.pop_front();
          if (m_tuser !== want.kind || m_tdata[63:0] !== want.value ||
              m_tdata[71:64] !== want.ch || m_tdata[72] !== want.fin ||
              m_tlast !== want.last || m_tdata[79:73] !== 7'd0) begin
            if (mismatches < 10) begin
              $write("%0t: token mismatch exp kind=%0d value=%0h ch=%0h fin=%b last=%b",
                     $realtime, want.kind, want.value, want.ch, want.fin, want.last);
              $display(" | got kind=%0d value=%0h ch=%0h fin=%b last=%b pad=%0h",
                       m_tuser, m_tdata[63:0], m_tdata[71:64], m_tdata[72], m_tlast,
                       m_tdata[79:73]);
            end
            mismatches++;
          end
        end
      end
      pending <= token_q.size();
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Bench top for sexpr_byte_tokenizer_unit: clock, reset, byte stimulus and verdict.
// Depends on sbt_pkg, the unit under test and sbt_token_check.
`timescale 1ns / 1ps

module testbench;
  import sbt_pkg::*;

  localparam int STALL_LIMIT  = 2000; // cycles with no transaction on either side
  localparam int TAIL_CYCLES  = 12;   // unit latency plus queue depth, with margin
  localparam int RANDOM_ITEMS = 450;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  int   fail_count;
  int   pending;
  int   sent_count  = 0;
  int   stall_count = 0;
  logic calm        = 1'b0;

  logic [7:0] line_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sexpr_byte_tokenizer_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  sbt_token_check u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // receiver backpressure: about 27% stall cycles, none during the calm stretch
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 27);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  function automatic logic quiet_stretch();
    return sent_count >= 150 && sent_count < 260;
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    return c == CH_NUL || c == CH_SPACE || c == CH_TAB || c == CH_NL ||
           c == CH_QUOTE || c == CH_LPAREN || c == CH_RPAREN;
  endfunction

  // one byte transaction; sender idles ~27% of cycles outside the calm stretch
  task automatic send_byte(logic [7:0] b);
    calm <= quiet_stretch();
    while (!quiet_stretch() && $urandom_range(0, 99) < 27) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom_range(0, 255));
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // hold the sender off until every owed token has been taken
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic push_number();
    int sel;
    int len;
    sel = $urandom_range(0, 2);
    if (sel == 1) line_q.push_back(CH_PLUS);
    if (sel == 2) line_q.push_back(CH_MINUS);
    sel = $urandom_range(0, 99);
    if (sel < 85) begin
      len = $urandom_range(1, 4);
    end else if (sel < 95) begin
      len = $urandom_range(17, 22);  // the longest of these wrap past 64 bits
    end else begin
      len = 0;
      case ($urandom_range(0, 3))
        0: push_str("9223372036854775807");
        1: push_str("9223372036854775808");
        2: push_str("18446744073709551615");
        default: push_str("18446744073709551616");
      endcase
    end
    repeat (len) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic push_symbol();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (is_delim(c) || (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS ||
           c == CH_MINUS);
    line_q.push_back(c);
    repeat ($urandom_range(0, 4)) begin
      do c = 8'($urandom_range(1, 255));
      while (is_delim(c));
      line_q.push_back(c);
    end
  endtask

  task automatic push_blank();
    case ($urandom_range(0, 2))
      0: line_q.push_back(CH_SPACE);
      1: line_q.push_back(CH_TAB);
      default: line_q.push_back(CH_NL);
    endcase
  endtask

  // a line of well-formed tokens with some noise mixed in
  task automatic build_line();
    int pick;
    line_q.delete();
    repeat ($urandom_range(1, 8)) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)      line_q.push_back(CH_LPAREN);
      else if (pick < 20) line_q.push_back(CH_RPAREN);
      else if (pick < 26) line_q.push_back(CH_QUOTE);
      else if (pick < 56) push_number();
      else if (pick < 80) push_symbol();
      else if (pick < 88) line_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      else                line_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 60) begin
        push_blank();
        if ($urandom_range(0, 3) == 0) push_blank();
      end
    end
    // most lines end; the rest run on into the next one
    if ($urandom_range(0, 9) != 0) line_q.push_back(CH_NUL);
  endtask

  initial begin
    int   random_base;
    logic drained_mid;
    drained_mid = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: every token kind, sign handling, number and symbol ends, high byte
    send_str("(-42 +x)'");
    send_byte(8'hFF);       // high byte starts a symbol, digit continues it
    send_str("9");
    send_byte(CH_NL);
    send_str("-");          // lone sign ended by a tab
    send_byte(CH_TAB);
    send_byte(CH_NUL);
    send_str("7(5");        // number ended by a paren, then flushed by end of line
    send_byte(CH_NUL);
    send_str("a");
    send_byte(CH_NUL);
    drain();

    random_base = sent_count;
    while (sent_count - random_base < RANDOM_ITEMS) begin
      build_line();
      foreach (line_q[i]) send_byte(line_q[i]);
      if (!drained_mid && sent_count - random_base >= RANDOM_ITEMS / 2) begin
        drain();
        drained_mid = 1'b1;
      end
    end
    calm <= 1'b0;
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
